FILE: design/ltr_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and tables of the LED trail two-cursor renderer.
package ltr_pkg;

    // Strip and ball geometry.
    localparam int NUM_PIXELS     = 117;
    localparam int BALL_WIDTH     = 7;
    localparam int STEPS_PER_TURN = 24;
    localparam int HALF_WIDTH     = BALL_WIDTH / 2;
    localparam int HALF_DIV       = (HALF_WIDTH > 0) ? HALF_WIDTH : 1;

    // Field widths.
    localparam int COUNT_W     = 15;
    localparam int PIXEL_W     = 7;
    localparam int LEVEL_W     = 16;
    localparam int CHANNEL_W   = 8;
    localparam int COLOR_W     = 3 * CHANNEL_W;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Stream packing, padded to whole bytes.
    localparam int IN_FIELDS_W  = 2 * COUNT_W + PIXEL_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int IN_PAD_W     = IN_TDATA_W - IN_FIELDS_W;
    localparam int OUT_FIELDS_W = PIXEL_W + COLOR_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    // Trail store addressing.
    localparam int ADDR_W = $clog2(NUM_PIXELS);

    // Full scale of a Q0.16 level and the colour scales.
    localparam int FULL_LEVEL  = 65535;
    localparam int FULL_SCALE  = 255;
    localparam int HALF_SCALE  = 128;

    // Register reset values.
    localparam logic [CFG_DATA_W-1:0] FADE_RESET  = 16'd60293;
    localparam logic [CFG_DATA_W-1:0] FLOOR_RESET = 16'd655;
    localparam logic [CFG_DATA_W-1:0] GAIN_RESET  = 16'd52428;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FADE_FACTOR = 2'd0,
        CFG_FLOOR_LEVEL = 2'd1,
        CFG_SECOND_GAIN = 2'd2
    } cfg_index_t;

    // Centre mapping: x = count*(N-1), reduced modulo N*STEPS by a reciprocal.
    localparam int SPAN         = NUM_PIXELS * STEPS_PER_TURN;
    localparam int X_W          = COUNT_W + $clog2(NUM_PIXELS);
    localparam int RECIP_SPAN   = (1 << X_W) / SPAN;
    localparam int RECIP_SPAN_W = $clog2(RECIP_SPAN + 1);
    localparam int R0_W         = $clog2(2 * SPAN);

    // Rounded division of u = 2r + STEPS by 2*STEPS.
    localparam int TWO_STEPS    = 2 * STEPS_PER_TURN;
    localparam int U_W          = $clog2(2 * SPAN + STEPS_PER_TURN);
    localparam int RECIP_U      = (1 << U_W) / TWO_STEPS;
    localparam int RECIP_U_W    = $clog2(RECIP_U + 1);
    localparam int C_W          = $clog2(NUM_PIXELS + 1);

    // Pixel to centre distance.
    localparam int DIFF_W = ((C_W > PIXEL_W) ? C_W : PIXEL_W) + 1;
    localparam int HW_W   = $clog2(HALF_WIDTH + 1);

    // Colour scaling: level*scale divided by the full level through a reciprocal.
    localparam int COLOR_X_W    = LEVEL_W + CHANNEL_W;
    localparam int RECIP_FULL   = (1 << COLOR_X_W) / FULL_LEVEL;
    localparam int RECIP_FULL_W = $clog2(RECIP_FULL + 1);

    // Ball brightness by remaining distance to the edge, h - d.
    typedef logic [LEVEL_W-1:0] ball_table_t [0:HALF_WIDTH];

    function automatic ball_table_t make_ball_table();
        ball_table_t t;
        for (int k = 0; k <= HALF_WIDTH; k++) begin
            t[k] = LEVEL_W'((k * FULL_LEVEL) / HALF_DIV);
        end
        return t;
    endfunction

    localparam ball_table_t BALL_TABLE = make_ball_table();

endpackage

FILE: design/ltr_centre.sv
`timescale 1ns / 1ps
// Pipelined mapping of one encoder count to its rounded ball centre on the strip.
module ltr_centre (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [ltr_pkg::COUNT_W-1:0] count,
    output logic [ltr_pkg::C_W-1:0]     centre
);

    localparam int PROD_SPAN_W = ltr_pkg::X_W + ltr_pkg::RECIP_SPAN_W;
    localparam int PROD_U_W    = ltr_pkg::U_W + ltr_pkg::RECIP_U_W;

    logic [ltr_pkg::X_W-1:0]          x_reg;
    logic [ltr_pkg::X_W-1:0]          x2_reg;
    logic [ltr_pkg::RECIP_SPAN_W-1:0] qe_reg;
    logic [ltr_pkg::R0_W-1:0]         r0_reg;
    logic [ltr_pkg::U_W-1:0]          u_reg;
    logic [ltr_pkg::U_W-1:0]          u2_reg;
    logic [ltr_pkg::RECIP_U_W-1:0]    ce_reg;
    logic [ltr_pkg::C_W-1:0]          centre_reg;

    logic [PROD_SPAN_W-1:0]           prod_span;
    logic [ltr_pkg::X_W-1:0]          rem_wide;
    logic [ltr_pkg::R0_W-1:0]         r_fix;
    logic [ltr_pkg::U_W-1:0]          u_next;
    logic [PROD_U_W-1:0]              prod_u;
    logic [ltr_pkg::U_W-1:0]          u_rem;
    logic [ltr_pkg::C_W-1:0]          centre_next;

    // Quotient estimate of x by the span, low by at most one.
    assign prod_span = PROD_SPAN_W'(x_reg) * PROD_SPAN_W'(ltr_pkg::RECIP_SPAN);

    // Remainder before correction stays below twice the span.
    assign rem_wide = x2_reg - ltr_pkg::X_W'(qe_reg * ltr_pkg::SPAN);

    // One corrective subtract, then form 2r + STEPS for rounding half up.
    always_comb begin
        if (r0_reg >= ltr_pkg::R0_W'(ltr_pkg::SPAN)) begin
            r_fix = r0_reg - ltr_pkg::R0_W'(ltr_pkg::SPAN);
        end else begin
            r_fix = r0_reg;
        end
        u_next = ltr_pkg::U_W'({r_fix, 1'b0}) + ltr_pkg::U_W'(ltr_pkg::STEPS_PER_TURN);
    end

    // Quotient estimate of u by twice the steps per turn.
    assign prod_u = PROD_U_W'(u_reg) * PROD_U_W'(ltr_pkg::RECIP_U);

    // Final correction of the centre.
    always_comb begin
        u_rem = u2_reg - ltr_pkg::U_W'(ce_reg * ltr_pkg::TWO_STEPS);
        if (u_rem >= ltr_pkg::U_W'(ltr_pkg::TWO_STEPS)) begin
            centre_next = ltr_pkg::C_W'(ce_reg) + ltr_pkg::C_W'(1);
        end else begin
            centre_next = ltr_pkg::C_W'(ce_reg);
        end
    end

    // Pipeline registers, advanced together with the rest of the block.
    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg      <= ltr_pkg::X_W'(count * (ltr_pkg::NUM_PIXELS - 1));
            x2_reg     <= x_reg;
            qe_reg     <= prod_span[ltr_pkg::X_W +: ltr_pkg::RECIP_SPAN_W];
            r0_reg     <= ltr_pkg::R0_W'(rem_wide);
            u_reg      <= u_next;
            u2_reg     <= u_reg;
            ce_reg     <= prod_u[ltr_pkg::U_W +: ltr_pkg::RECIP_U_W];
            centre_reg <= centre_next;
        end
    end

    assign centre = centre_reg;

endmodule

FILE: design/led_trail_two_cursor_renderer.sv
`timescale 1ns / 1ps
// Top level of the LED trail two-cursor renderer.
//
// Each request on the s_ channel carries two encoder counts and one strip pixel
// index. The block maps both counts to ball centres, fades the pixel's trail
// level, raises it to the two ball brightnesses, writes it back to the trail
// store and returns one result on the m_ channel: the pixel index and its GRB
// colour. Registers are written on the cfg_ channel.
//
// Registers must be written only while the block is idle; the block does not
// enforce it. One request is accepted in every cycle while the output buffer has
// room. The trail store is read ahead of a read-modify-write that forwards the
// level just written, so requests to one pixel may follow each other directly.
//
// A two-entry output buffer sits behind the pipeline. The pipeline moves
// while that buffer has a free entry, so one finished result may wait while
// new requests are still taken; s_tready falls only when both entries are held.
//
// Reset (aresetn low at a clock edge) empties the pipeline and the output
// buffer, restores the register defaults and marks every trail entry as
// zero through per-entry valid bits, so no clearing pass is needed.
module led_trail_two_cursor_renderer (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input requests.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // count_one, count_two, pixel_index, zero padding
    input  logic [ltr_pkg::IN_TDATA_W-1:0]  s_tdata,
    // Results.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // pixel_number, pixel_color, zero padding
    output logic [ltr_pkg::OUT_TDATA_W-1:0] m_tdata,
    // Register writes.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ltr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ltr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int DELAY = 7;

    // Configuration registers.
    logic [ltr_pkg::LEVEL_W-1:0] fade_reg;
    logic [ltr_pkg::LEVEL_W-1:0] floor_reg;
    logic [ltr_pkg::LEVEL_W-1:0] gain_reg;

    // Pipeline control.
    logic en;
    logic accept;

    // Stages one to seven: counts, pixel and valid delay line.
    logic [ltr_pkg::COUNT_W-1:0] cnt_one_reg;
    logic [ltr_pkg::COUNT_W-1:0] cnt_two_reg;
    logic [ltr_pkg::PIXEL_W-1:0] pix_pipe_reg [1:DELAY];
    logic                        vld_pipe_reg [1:DELAY];
    logic [ltr_pkg::C_W-1:0]     centre_one;
    logic [ltr_pkg::C_W-1:0]     centre_two;

    // Stage seven logic.
    logic [ltr_pkg::DIFF_W-1:0]  dist_one;
    logic [ltr_pkg::DIFF_W-1:0]  dist_two;

    // Stage eight.
    logic [ltr_pkg::LEVEL_W-1:0] s8_b1_reg;
    logic [ltr_pkg::LEVEL_W-1:0] s8_b2raw_reg;
    logic                        s8_near_reg;
    logic [ltr_pkg::PIXEL_W-1:0] s8_pix_reg;
    logic                        s8_vld_reg;
    logic [2*ltr_pkg::LEVEL_W-1:0] gain_prod;
    logic [ltr_pkg::ADDR_W-1:0]  rd_addr;

    // Stage nine: read-modify-write of the trail store.
    logic [ltr_pkg::LEVEL_W-1:0] s9_b1_reg;
    logic [ltr_pkg::LEVEL_W-1:0] s9_b2_reg;
    logic                        s9_near_reg;
    logic [ltr_pkg::PIXEL_W-1:0] s9_pix_reg;
    logic                        s9_vld_reg;
    logic [ltr_pkg::LEVEL_W-1:0] rd_data_reg;
    logic                        rd_valid_reg;
    logic                        s9_inr;
    logic                        fwd;
    logic [ltr_pkg::LEVEL_W-1:0] old_level;
    logic [2*ltr_pkg::LEVEL_W-1:0] fade_prod;
    logic [ltr_pkg::LEVEL_W-1:0] floored;
    logic [ltr_pkg::LEVEL_W-1:0] level_next;
    logic                        mem_we;
    logic [ltr_pkg::ADDR_W-1:0]  wr_addr;

    // Trail store and its valid bits.
    logic [ltr_pkg::LEVEL_W-1:0]    trail_mem [0:ltr_pkg::NUM_PIXELS-1];
    logic [ltr_pkg::NUM_PIXELS-1:0] entry_valid_reg;

    // Stage ten.
    logic [ltr_pkg::LEVEL_W-1:0] s10_lvl_reg;
    logic                        s10_near_reg;
    logic [ltr_pkg::PIXEL_W-1:0] s10_pix_reg;
    logic                        s10_vld_reg;
    logic                        s10_inr_reg;

    // Stage eleven.
    logic [ltr_pkg::COLOR_X_W-1:0] s11_xf_reg;
    logic [ltr_pkg::COLOR_X_W-1:0] s11_xh_reg;
    logic                          s11_near_reg;
    logic                          s11_lit_reg;
    logic [ltr_pkg::PIXEL_W-1:0]   s11_pix_reg;
    logic                          s11_vld_reg;
    logic [ltr_pkg::COLOR_X_W+ltr_pkg::RECIP_FULL_W-1:0] prod_f;
    logic [ltr_pkg::COLOR_X_W+ltr_pkg::RECIP_FULL_W-1:0] prod_h;

    // Stage twelve.
    logic [ltr_pkg::COLOR_X_W-1:0] s12_xf_reg;
    logic [ltr_pkg::COLOR_X_W-1:0] s12_xh_reg;
    logic [ltr_pkg::CHANNEL_W-1:0] s12_qf_reg;
    logic [ltr_pkg::CHANNEL_W-1:0] s12_qh_reg;
    logic                          s12_near_reg;
    logic                          s12_lit_reg;
    logic [ltr_pkg::PIXEL_W-1:0]   s12_pix_reg;
    logic                          s12_vld_reg;
    logic [ltr_pkg::CHANNEL_W-1:0] full_chan;
    logic [ltr_pkg::CHANNEL_W-1:0] half_chan;
    logic [ltr_pkg::COLOR_W-1:0]   color;

    // Output buffer.
    logic [ltr_pkg::OUT_TDATA_W-1:0] slot_reg [0:1];
    logic                            wr_ptr_reg;
    logic                            rd_ptr_reg;
    logic [1:0]                      count_reg;
    logic [1:0]                      count_next;
    logic                            push;
    logic                            pop;

    // Distance between a pixel and a centre.
    function automatic logic [ltr_pkg::DIFF_W-1:0] pix_dist(
        input logic [ltr_pkg::PIXEL_W-1:0] p,
        input logic [ltr_pkg::C_W-1:0]     c
    );
        logic [ltr_pkg::DIFF_W-1:0] pe;
        logic [ltr_pkg::DIFF_W-1:0] ce;
        pe = ltr_pkg::DIFF_W'(p);
        ce = ltr_pkg::DIFF_W'(c);
        return (pe >= ce) ? pe - ce : ce - pe;
    endfunction

    // Triangular ball brightness for a distance.
    function automatic logic [ltr_pkg::LEVEL_W-1:0] ball_of(
        input logic [ltr_pkg::DIFF_W-1:0] d
    );
        logic [ltr_pkg::LEVEL_W-1:0] b;
        b = '0;
        if (d < ltr_pkg::DIFF_W'(ltr_pkg::HALF_WIDTH)) begin
            b = ltr_pkg::BALL_TABLE[ltr_pkg::HW_W'(ltr_pkg::HALF_WIDTH - d)];
        end
        return b;
    endfunction

    // Handshakes: the whole pipeline moves while the output buffer has room.
    assign en        = (count_reg != 2'd2);
    assign s_tready  = en;
    assign accept    = s_tvalid && en;
    assign cfg_ready = 1'b1;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fade_reg  <= ltr_pkg::FADE_RESET;
            floor_reg <= ltr_pkg::FLOOR_RESET;
            gain_reg  <= ltr_pkg::GAIN_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                ltr_pkg::CFG_FADE_FACTOR: fade_reg  <= cfg_data;
                ltr_pkg::CFG_FLOOR_LEVEL: floor_reg <= cfg_data;
                ltr_pkg::CFG_SECOND_GAIN: gain_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Valid bits of the pipeline stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 1; i <= DELAY; i++) begin
                vld_pipe_reg[i] <= 1'b0;
            end
            s8_vld_reg  <= 1'b0;
            s9_vld_reg  <= 1'b0;
            s10_vld_reg <= 1'b0;
            s11_vld_reg <= 1'b0;
            s12_vld_reg <= 1'b0;
        end else if (en) begin
            vld_pipe_reg[1] <= accept;
            for (int i = 2; i <= DELAY; i++) begin
                vld_pipe_reg[i] <= vld_pipe_reg[i-1];
            end
            s8_vld_reg  <= vld_pipe_reg[DELAY];
            s9_vld_reg  <= s8_vld_reg;
            s10_vld_reg <= s9_vld_reg;
            s11_vld_reg <= s10_vld_reg;
            s12_vld_reg <= s11_vld_reg;
        end
    end

    // Input capture and pixel delay line alongside the centre pipelines.
    always_ff @(posedge aclk) begin
        if (en) begin
            cnt_one_reg     <= s_tdata[0 +: ltr_pkg::COUNT_W];
            cnt_two_reg     <= s_tdata[ltr_pkg::COUNT_W +: ltr_pkg::COUNT_W];
            pix_pipe_reg[1] <= s_tdata[2*ltr_pkg::COUNT_W +: ltr_pkg::PIXEL_W];
            for (int i = 2; i <= DELAY; i++) begin
                pix_pipe_reg[i] <= pix_pipe_reg[i-1];
            end
        end
    end

    ltr_centre u_centre_one (
        .aclk   (aclk),
        .en     (en),
        .count  (cnt_one_reg),
        .centre (centre_one)
    );

    ltr_centre u_centre_two (
        .aclk   (aclk),
        .en     (en),
        .count  (cnt_two_reg),
        .centre (centre_two)
    );

    // Ball brightness of both cursors and which centre is nearer.
    assign dist_one = pix_dist(pix_pipe_reg[DELAY], centre_one);
    assign dist_two = pix_dist(pix_pipe_reg[DELAY], centre_two);

    always_ff @(posedge aclk) begin
        if (en) begin
            s8_b1_reg    <= ball_of(dist_one);
            s8_b2raw_reg <= ball_of(dist_two);
            s8_near_reg  <= (dist_one < dist_two);
            s8_pix_reg   <= pix_pipe_reg[DELAY];
        end
    end

    // Second ball scaled by its gain; trail read issued one stage ahead.
    assign gain_prod = (2*ltr_pkg::LEVEL_W)'(s8_b2raw_reg) * (2*ltr_pkg::LEVEL_W)'(gain_reg);
    assign rd_addr   = ltr_pkg::ADDR_W'(s8_pix_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            s9_b1_reg    <= s8_b1_reg;
            s9_b2_reg    <= gain_prod[ltr_pkg::LEVEL_W +: ltr_pkg::LEVEL_W];
            s9_near_reg  <= s8_near_reg;
            s9_pix_reg   <= s8_pix_reg;
            rd_data_reg  <= trail_mem[rd_addr];
            rd_valid_reg <= entry_valid_reg[rd_addr];
        end
    end

    // Fade, floor and raise the level; the previous request's write is forwarded.
    always_comb begin
        s9_inr = (s9_pix_reg < ltr_pkg::PIXEL_W'(ltr_pkg::NUM_PIXELS));
        fwd    = s10_vld_reg && s10_inr_reg && (s10_pix_reg == s9_pix_reg);
        if (fwd) begin
            old_level = s10_lvl_reg;
        end else if (rd_valid_reg) begin
            old_level = rd_data_reg;
        end else begin
            old_level = '0;
        end
        fade_prod = (2*ltr_pkg::LEVEL_W)'(old_level) * (2*ltr_pkg::LEVEL_W)'(fade_reg);
        floored   = fade_prod[ltr_pkg::LEVEL_W +: ltr_pkg::LEVEL_W];
        if (floored < floor_reg) begin
            floored = '0;
        end
        level_next = floored;
        if (s9_b1_reg > level_next) begin
            level_next = s9_b1_reg;
        end
        if (s9_b2_reg > level_next) begin
            level_next = s9_b2_reg;
        end
        mem_we  = en && s9_vld_reg && s9_inr;
        wr_addr = ltr_pkg::ADDR_W'(s9_pix_reg);
    end

    // Trail store write port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            trail_mem[wr_addr] <= level_next;
        end
    end

    // Entries read as zero until first written after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
        end else if (mem_we) begin
            entry_valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s10_lvl_reg  <= level_next;
            s10_near_reg <= s9_near_reg;
            s10_pix_reg  <= s9_pix_reg;
            s10_inr_reg  <= s9_inr;
        end
    end

    // Scale the level for the full and half colour channels.
    always_ff @(posedge aclk) begin
        if (en) begin
            s11_xf_reg   <= ltr_pkg::COLOR_X_W'(s10_lvl_reg * ltr_pkg::FULL_SCALE);
            s11_xh_reg   <= ltr_pkg::COLOR_X_W'(s10_lvl_reg * ltr_pkg::HALF_SCALE);
            s11_near_reg <= s10_near_reg;
            s11_lit_reg  <= s10_inr_reg && (s10_lvl_reg > floor_reg);
            s11_pix_reg  <= s10_pix_reg;
        end
    end

    // Quotient estimates by the full level, low by at most one.
    assign prod_f = (ltr_pkg::COLOR_X_W + ltr_pkg::RECIP_FULL_W)'(s11_xf_reg)
                  * (ltr_pkg::COLOR_X_W + ltr_pkg::RECIP_FULL_W)'(ltr_pkg::RECIP_FULL);
    assign prod_h = (ltr_pkg::COLOR_X_W + ltr_pkg::RECIP_FULL_W)'(s11_xh_reg)
                  * (ltr_pkg::COLOR_X_W + ltr_pkg::RECIP_FULL_W)'(ltr_pkg::RECIP_FULL);

    always_ff @(posedge aclk) begin
        if (en) begin
            s12_xf_reg   <= s11_xf_reg;
            s12_xh_reg   <= s11_xh_reg;
            s12_qf_reg   <= prod_f[ltr_pkg::COLOR_X_W +: ltr_pkg::CHANNEL_W];
            s12_qh_reg   <= prod_h[ltr_pkg::COLOR_X_W +: ltr_pkg::CHANNEL_W];
            s12_near_reg <= s11_near_reg;
            s12_lit_reg  <= s11_lit_reg;
            s12_pix_reg  <= s11_pix_reg;
        end
    end

    // Correct the quotients and assemble the GRB word.
    always_comb begin
        full_chan = s12_qf_reg;
        if (s12_xf_reg - ltr_pkg::COLOR_X_W'(s12_qf_reg * ltr_pkg::FULL_LEVEL)
                >= ltr_pkg::COLOR_X_W'(ltr_pkg::FULL_LEVEL)) begin
            full_chan = s12_qf_reg + ltr_pkg::CHANNEL_W'(1);
        end
        half_chan = s12_qh_reg;
        if (s12_xh_reg - ltr_pkg::COLOR_X_W'(s12_qh_reg * ltr_pkg::FULL_LEVEL)
                >= ltr_pkg::COLOR_X_W'(ltr_pkg::FULL_LEVEL)) begin
            half_chan = s12_qh_reg + ltr_pkg::CHANNEL_W'(1);
        end
        if (!s12_lit_reg) begin
            color = '0;
        end else if (s12_near_reg) begin
            // Cyan: green and blue.
            color = {full_chan, {ltr_pkg::CHANNEL_W{1'b0}}, full_chan};
        end else begin
            // Magenta: red with half blue.
            color = {{ltr_pkg::CHANNEL_W{1'b0}}, full_chan, half_chan};
        end
    end

    // Two-entry output buffer.
    assign push = en && s12_vld_reg;
    assign pop  = (count_reg != 2'd0) && m_tready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= {{ltr_pkg::OUT_PAD_W{1'b0}}, color, s12_pix_reg};
        end
    end

    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = slot_reg[rd_ptr_reg];

endmodule

FILE: test/led_trail_two_cursor_renderer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the LED trail two-cursor renderer, with a colour predictor.
module led_trail_two_cursor_renderer_test;

    import ltr_pkg::*;

    // One expected result: the pixel echoed and its GRB colour.
    typedef struct packed {
        logic [PIXEL_W-1:0] number;
        logic [COLOR_W-1:0] colour;
    } pixel_result_t;

    // Keeps its own copy of the trail store and registers, predicts the colour of every
    // accepted request and checks the results in order.
    class pixel_colour_scoreboard;
        int unsigned   fade;
        int unsigned   floor_lvl;
        int unsigned   gain;
        int unsigned   trail [NUM_PIXELS];
        pixel_result_t pending_pixels [$];
        int            errors;

        function new();
            fade      = FADE_RESET;
            floor_lvl = FLOOR_RESET;
            gain      = GAIN_RESET;
            errors    = 0;
            foreach (trail[i]) trail[i] = 0;
        endfunction

        task report(input string msg);
            $display("%t mismatch: %s", $realtime, msg);
            errors++;
        endtask

        function void set_register(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_FADE_FACTOR: fade = val;
                CFG_FLOOR_LEVEL: floor_lvl = val;
                CFG_SECOND_GAIN: gain = val;
                default: ;
            endcase
        endfunction

        // Rounded strip position of an encoder count; wrapping comes before rounding,
        // so the result may equal the strip length.
        function int centre_of(input logic [COUNT_W-1:0] count);
            longint unsigned r;
            r = (longint'(count) * (NUM_PIXELS - 1)) % (NUM_PIXELS * STEPS_PER_TURN);
            return int'((2 * r + STEPS_PER_TURN) / (2 * STEPS_PER_TURN));
        endfunction

        // Triangular brightness of a ball centred at c, seen from pixel p.
        function int unsigned ball_of(input int p, input int c);
            int off;
            int d;
            off = p - c + HALF_WIDTH;
            d   = (p >= c) ? p - c : c - p;
            if (off < 0 || off >= BALL_WIDTH)
                return 0;
            if (HALF_WIDTH == 0)
                return (d == 0) ? FULL_LEVEL : 0;
            if (d >= HALF_WIDTH)
                return 0;
            return ((HALF_WIDTH - d) * FULL_LEVEL) / HALF_DIV;
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction

        // Updates the trail entry of an accepted request and queues the colour it shows.
        function void note_request(input logic [COUNT_W-1:0] count_a,
                                   input logic [COUNT_W-1:0] count_b,
                                   input logic [PIXEL_W-1:0] pix);
            pixel_result_t res;
            int            c1;
            int            c2;
            int            p;
            int            d1;
            int            d2;
            int unsigned   lvl;
            int unsigned   b1;
            int unsigned   b2;
            logic [7:0]    g;
            logic [7:0]    r;
            logic [7:0]    b;
            c1 = centre_of(count_a);
            c2 = centre_of(count_b);
            p  = pix;
            res.number = pix;
            res.colour = '0;
            if (p < NUM_PIXELS) begin
                lvl = int'((longint'(trail[p]) * fade) >> 16);
                if (lvl < floor_lvl)
                    lvl = 0;
                b1 = ball_of(p, c1);
                if (b1 > lvl)
                    lvl = b1;
                b2 = int'((longint'(ball_of(p, c2)) * gain) >> 16);
                if (b2 > lvl)
                    lvl = b2;
                trail[p] = lvl;
                if (lvl > floor_lvl) begin
                    d1 = (p >= c1) ? p - c1 : c1 - p;
                    d2 = (p >= c2) ? p - c2 : c2 - p;
                    // Strictly nearer the first centre shows cyan, a tie shows magenta.
                    if (d1 < d2) begin
                        r = 8'd0;
                        g = 8'((FULL_SCALE * lvl) / FULL_LEVEL);
                        b = g;
                    end else begin
                        r = 8'((FULL_SCALE * lvl) / FULL_LEVEL);
                        g = 8'd0;
                        b = 8'((HALF_SCALE * lvl) / FULL_LEVEL);
                    end
                    res.colour = {g, r, b};
                end
            end
            pending_pixels.push_back(res);
        endfunction

        task check_result(input logic [PIXEL_W-1:0] number, input logic [COLOR_W-1:0] colour);
            pixel_result_t want;
            if (pending_pixels.size() == 0) begin
                report($sformatf("unexpected result pixel %0d colour %06h", number, colour));
            end else begin
                want = pending_pixels.pop_front();
                if (number !== want.number)
                    report($sformatf("pixel number %0d, expected %0d", number, want.number));
                if (colour !== want.colour)
                    report($sformatf("pixel %0d colour %06h, expected %06h",
                                     want.number, colour, want.colour));
            end
        endtask
    endclass

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata   = '0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data  = '0;

    // Set for the last phase, where neither side idles.
    bit calm = 1'b0;

    pixel_colour_scoreboard sb = new();

    led_trail_two_cursor_renderer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Result channel: check every accepted result.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata[PIXEL_W-1:0], m_tdata[PIXEL_W +: COLOR_W]);
    end

    // Result channel back-pressure in random bursts.
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        m_tready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (!calm && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    // Hard limit on the length of the run.
    initial begin
        #5000000;
        $display("*** FAILED ***");
        $finish;
    end

    // Offers one request and waits for it to be taken, then maybe idles for a while.
    task automatic send_request(input logic [COUNT_W-1:0] count_a,
                                input logic [COUNT_W-1:0] count_b,
                                input logic [PIXEL_W-1:0] pix);
        s_tdata  <= {{IN_PAD_W{1'b0}}, pix, count_b, count_a};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(count_a, count_b, pix);
        if (!calm && $urandom_range(0, 11) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.set_register(idx, val);
        @(posedge aclk);
    endtask

    task automatic wait_until_drained();
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // The input side stops offering before the block drains and the registers change.
    task automatic configure(input logic [CFG_DATA_W-1:0] fade,
                             input logic [CFG_DATA_W-1:0] floor_lvl,
                             input logic [CFG_DATA_W-1:0] gain);
        s_tvalid <= 1'b0;
        wait_until_drained();
        write_register(CFG_FADE_FACTOR, fade);
        write_register(CFG_FLOOR_LEVEL, floor_lvl);
        write_register(CFG_SECOND_GAIN, gain);
    endtask

    // Field extremes, both colours, a tie, a centre past the last pixel and
    // indexes beyond the strip.
    task automatic directed_requests();
        send_request(15'd0, 15'd0, 7'd0);
        send_request(15'd0, 15'd0, 7'd0);
        send_request(15'h7fff, 15'h7fff, 7'd127);
        send_request(15'h7fff, 15'd0, 7'd117);
        send_request(15'd0, 15'h7fff, 7'd116);
        // A count of 363 rounds to a centre one past the last pixel.
        send_request(15'd363, 15'd0, 7'd116);
        send_request(15'd363, 15'd0, 7'd115);
        send_request(15'd363, 15'd0, 7'd114);
        send_request(15'd0, 15'd363, 7'd1);
        send_request(15'd0, 15'd363, 7'd2);
        send_request(15'd0, 15'd363, 7'd3);
        send_request(15'd363, 15'd363, 7'd116);
        // Faded trails with no ball nearby.
        send_request(15'h4000, 15'h2000, 7'd1);
        send_request(15'h4000, 15'h2000, 7'd1);
        send_request(15'h4000, 15'h2000, 7'd116);
        send_request(15'h4000, 15'h2000, 7'd0);
        // Second ball alone, then both balls on one pixel.
        send_request(15'h2aaa, 15'd24, 7'(sb.centre_of(15'd24)));
        send_request(15'd24, 15'd24, 7'(sb.centre_of(15'd24)));
        send_request(15'd25, 15'd24, 7'(sb.centre_of(15'd24) + 1));
        send_request(15'h5555, 15'h5555, 7'(sb.centre_of(15'h5555)));
        send_request(15'h1234, 15'h7ffe, 7'd64);
        send_request(15'd0, 15'd0, 7'd126);
    endtask

    // Mostly sweeps of neighbouring pixels around a slowly turning ball, with
    // random requests in between, some of them beyond the strip.
    task automatic random_requests(input int count);
        logic [COUNT_W-1:0] enc_a;
        logic [COUNT_W-1:0] enc_b;
        int                 sent;
        int                 start;
        int                 len;
        int                 hold;
        int                 p;
        sent  = 0;
        enc_a = COUNT_W'($urandom);
        enc_b = COUNT_W'($urandom);
        while (sent < count) begin
            if ($urandom_range(0, 9) < 3) begin
                send_request(COUNT_W'($urandom), COUNT_W'($urandom),
                             PIXEL_W'($urandom_range(0, 127)));
                sent++;
            end else begin
                // Encoders turn a little between sweeps and sometimes jump.
                enc_a = enc_a + COUNT_W'($urandom_range(0, 6)) - COUNT_W'(3);
                enc_b = enc_b + COUNT_W'($urandom_range(0, 6)) - COUNT_W'(3);
                if ($urandom_range(0, 19) == 0)
                    enc_a = COUNT_W'($urandom);
                if ($urandom_range(0, 19) == 0)
                    enc_b = COUNT_W'($urandom);
                start = $urandom_range(0, 1) ? sb.centre_of(enc_a) : sb.centre_of(enc_b);
                start = start - int'($urandom_range(0, 6));
                len   = $urandom_range(3, 20);
                hold  = ($urandom_range(0, 4) == 0) ? 2 : 1;
                for (int k = 0; k < len && sent < count; k++) begin
                    p = ((start + k) % NUM_PIXELS + NUM_PIXELS) % NUM_PIXELS;
                    repeat (hold) begin
                        send_request(enc_a, enc_b, PIXEL_W'(p));
                        sent++;
                    end
                end
            end
        end
    endtask

    // Main sequence: reset, directed requests, then random phases under
    // several register settings.
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed_requests();
        random_requests(220);

        configure(16'hffff, 16'h0000, 16'hffff);
        random_requests(220);
        configure(16'h0000, 16'hffff, 16'h0000);
        random_requests(220);
        configure(16'h8000, 16'h0001, 16'h0001);
        random_requests(220);
        configure(16'($urandom), 16'($urandom_range(0, 4000)), 16'($urandom));
        random_requests(220);
        configure(16'($urandom_range(50000, 65535)), 16'($urandom_range(0, 2000)),
                  16'($urandom));
        random_requests(220);

        // Last phase: defaults back and no idling on either side.
        configure(FADE_RESET, FLOOR_RESET, GAIN_RESET);
        calm = 1'b1;
        random_requests(220);
        s_tvalid <= 1'b0;

        wait_until_drained();
        repeat (30) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
